FILE: rtl/mppid_pkg.sv
// ----------------------------------------------------------------------------
// mppid_pkg: shared types and constants for the motor position PID core
// Microcode word layout, the control program, register indexes and the
// fixed arithmetic constants of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mppid_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd5;

  localparam logic [15:0] WINDUP_RESET = 16'hFFFF;
  localparam logic [6:0]  SPEED_RESET  = 7'd100;

  // arithmetic constants
  localparam int DIVISOR   = 100;
  localparam int REM_W     = 7;
  localparam int DIV_W     = 56;
  localparam int DIV_BYTES = DIV_W / 8;
  localparam int CNT_W     = 3;
  localparam int OUT_SCALE = 1000;
  localparam int MAG_MAX   = 65535;
  localparam int SAT_LIMIT = MAG_MAX / OUT_SCALE + 1;

  // operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_ERR   = 3'd1;
  localparam logic [2:0] OP_SUM   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_ACC   = 3'd5;
  localparam logic [2:0] OP_SCALE = 3'd6;
  localparam logic [2:0] OP_OUT   = 3'd7;
  // the percent multiply shares the OP_MUL code with its own operand select

  // operand selects for OP_MUL
  localparam logic [1:0] SEL_P   = 2'd0;
  localparam logic [1:0] SEL_I   = 2'd1;
  localparam logic [1:0] SEL_D   = 2'd2;
  localparam logic [1:0] SEL_PCT = 2'd3;

  // jump conditions
  localparam logic [1:0] JC_NEXT = 2'd0;
  localparam logic [1:0] JC_LOOP = 2'd1;
  localparam logic [1:0] JC_END  = 2'd2;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] PROG_LAST = 4'd14;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        sel;
    logic [1:0]        jc;
    logic [STEP_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, sel: SEL_P, jc: JC_END, tgt: 4'd0};
    case (step)
      4'd0:  w = '{op: OP_ERR,   sel: SEL_P,   jc: JC_NEXT, tgt: 4'd0};
      4'd1:  w = '{op: OP_SUM,   sel: SEL_P,   jc: JC_NEXT, tgt: 4'd0};
      4'd2:  w = '{op: OP_MUL,   sel: SEL_P,   jc: JC_NEXT, tgt: 4'd0};
      4'd3:  w = '{op: OP_DIV,   sel: SEL_P,   jc: JC_LOOP, tgt: 4'd3};
      4'd4:  w = '{op: OP_ACC,   sel: SEL_P,   jc: JC_NEXT, tgt: 4'd0};
      4'd5:  w = '{op: OP_MUL,   sel: SEL_I,   jc: JC_NEXT, tgt: 4'd0};
      4'd6:  w = '{op: OP_DIV,   sel: SEL_I,   jc: JC_LOOP, tgt: 4'd6};
      4'd7:  w = '{op: OP_ACC,   sel: SEL_I,   jc: JC_NEXT, tgt: 4'd0};
      4'd8:  w = '{op: OP_MUL,   sel: SEL_D,   jc: JC_NEXT, tgt: 4'd0};
      4'd9:  w = '{op: OP_DIV,   sel: SEL_D,   jc: JC_LOOP, tgt: 4'd9};
      4'd10: w = '{op: OP_ACC,   sel: SEL_D,   jc: JC_NEXT, tgt: 4'd0};
      4'd11: w = '{op: OP_SCALE, sel: SEL_P,   jc: JC_NEXT, tgt: 4'd0};
      4'd12: w = '{op: OP_MUL,   sel: SEL_PCT, jc: JC_NEXT, tgt: 4'd0};
      4'd13: w = '{op: OP_DIV,   sel: SEL_PCT, jc: JC_LOOP, tgt: 4'd13};
      4'd14: w = '{op: OP_OUT,   sel: SEL_P,   jc: JC_END,  tgt: 4'd0};
      default: w = '{op: OP_NOP, sel: SEL_P,   jc: JC_END,  tgt: 4'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/motor_position_pid_pwm_core.sv
// ----------------------------------------------------------------------------
// motor_position_pid_pwm_core: position PID with anti-windup and PWM output
// Microcoded controller for MOTOR_COUNT motors sharing one gain set.
// ----------------------------------------------------------------------------
// A control step runs a 15-step microprogram from the input transfer to the
// result landing in the output register: error, dead band and windup
// clamp, then for each of the P, I and D terms one multiply on the shared
// 34x16 multiplier, a pass through the byte-serial divide-by-100 unit and
// one accumulate, then output scaling, the speed-percent multiply with
// another divide, and the output load. A restart request yields no result.
// The block takes the next input the cycle after the result is registered,
// while that result still waits for its output transfer. No clearing pass
// after reset.
`default_nettype none

module motor_position_pid_pwm_core #(
  parameter int MOTOR_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic        side,
  input  logic signed [31:0] current_pos,
  input  logic signed [31:0] target_pos,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        motor_side,
  output logic [15:0] pwm_level,
  output logic        backward,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mppid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import mppid_pkg::*;

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // configuration
  logic [15:0] gain_p, gain_i, gain_d, windup_limit;
  logic [7:0]  dead_band;
  logic [6:0]  max_speed_pct;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      windup_limit  <= WINDUP_RESET;
      dead_band     <= '0;
      max_speed_pct <= SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:       gain_p        <= cfg_data;
        REG_GAIN_I:       gain_i        <= cfg_data;
        REG_GAIN_D:       gain_d        <= cfg_data;
        REG_WINDUP_LIMIT: windup_limit  <= cfg_data;
        REG_DEAD_BAND:    dead_band     <= cfg_data[7:0];
        REG_MAX_SPEED:    max_speed_pct <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic              busy;
  logic [STEP_W-1:0] step;
  ucode_t            cw;
  logic              advance;
  logic              in_xfer;
  logic              div_last;

  assign cw       = ucode_rom(step);
  assign in_stall = busy;
  assign in_xfer  = in_valid && !in_stall;
  // hold the output step while the previous result is still stalled
  assign advance  = !(cw.op == OP_OUT && out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (!busy) begin
      if (in_xfer && !req_type) begin
        busy <= 1'b1;
        step <= '0;
      end
    end else if (advance) begin
      case (cw.jc)
        JC_NEXT: step <= step + 1'b1;
        JC_LOOP: step <= div_last ? step + 1'b1 : cw.tgt;
        JC_END:  busy <= 1'b0;
        default: busy <= 1'b0;
      endcase
    end
  end

  // captured request
  logic signed [31:0] cur_q, tgt_q;
  logic               side_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   in_idx;

  always_comb begin
    if ({31'b0, side} < 32'(MOTOR_COUNT)) begin
      in_idx = IDX_W'(side);
    end else begin
      in_idx = IDX_W'(MOTOR_COUNT - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_q  <= current_pos;
      tgt_q  <= target_pos;
      side_q <= side;
      idx_q  <= in_idx;
    end
  end

  // per-motor state
  logic signed [16:0] esum [MOTOR_COUNT];
  logic signed [32:0] prev [MOTOR_COUNT];
  logic signed [16:0] esum_rd;
  logic signed [32:0] prev_rd;

  assign esum_rd = esum[idx_q];
  assign prev_rd = prev[idx_q];

  // datapath
  logic signed [32:0] err_r;
  logic signed [16:0] sum_r;
  logic signed [33:0] diff_r;
  logic               term_neg;
  logic signed [47:0] acc;
  logic [15:0]        mag16;
  logic               back_r;

  logic signed [32:0] err_raw, err_dz;
  logic [32:0]        err_mag;
  logic signed [33:0] sum_raw, w_pos, w_neg, sum_cl, diff_next;
  logic signed [33:0] src;
  logic [33:0]        src_mag;
  logic [47:0]        acc_mag;
  logic [33:0]        mul_a;
  logic [15:0]        mul_b, gain_sel;
  logic [49:0]        prod;
  logic [DIV_W-1:0]   quot;
  logic [15:0]        mag_fin;
  div_ctl_t           div_ctl;

  always_comb begin
    err_raw = {tgt_q[31], tgt_q} - {cur_q[31], cur_q};
    err_mag = err_raw[32] ? 33'(-err_raw) : 33'(err_raw);
    err_dz  = (err_mag < {25'b0, dead_band}) ? '0 : err_raw;

    sum_raw = {{17{esum_rd[16]}}, esum_rd} + {err_r[32], err_r};
    w_pos   = {18'b0, windup_limit};
    w_neg   = -w_pos;
    // the windup limit never exceeds 65535, so it also covers the fixed clamp
    if (sum_raw > w_pos) begin
      sum_cl = w_pos;
    end else if (sum_raw < w_neg) begin
      sum_cl = w_neg;
    end else begin
      sum_cl = sum_raw;
    end
    diff_next = {err_r[32], err_r} - {prev_rd[32], prev_rd};

    case (cw.sel)
      SEL_P:   begin src = {err_r[32], err_r};            gain_sel = gain_p; end
      SEL_I:   begin src = {{17{sum_r[16]}}, sum_r};      gain_sel = gain_i; end
      SEL_D:   begin src = diff_r;                        gain_sel = gain_d; end
      default: begin src = '0;                            gain_sel = '0;     end
    endcase
    src_mag = src[33] ? 34'(-src) : 34'(src);
    acc_mag = acc[47] ? 48'(-acc) : 48'(acc);

    if (cw.op == OP_SCALE) begin
      mul_a = acc_mag[33:0];
      mul_b = 16'(OUT_SCALE);
    end else if (cw.sel == SEL_PCT) begin
      mul_a = {18'b0, mag16};
      mul_b = {9'b0, max_speed_pct};
    end else begin
      mul_a = src_mag;
      mul_b = gain_sel;
    end
    prod = 50'(mul_a) * 50'(mul_b);

    mag_fin = (|quot[DIV_W-1:16]) ? 16'(MAG_MAX) : quot[15:0];

    div_ctl.load = busy && (cw.op == OP_MUL);
    div_ctl.step = busy && (cw.op == OP_DIV);
  end

  mppid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .load_val ({{(DIV_W-50){1'b0}}, prod}),
    .quot     (quot),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (busy) begin
      case (cw.op)
        OP_ERR: err_r <= err_dz;
        OP_SUM: begin
          sum_r  <= 17'(sum_cl);
          diff_r <= diff_next;
          acc    <= '0;
        end
        OP_MUL: term_neg <= src[33];
        OP_ACC: acc <= term_neg ? acc - $signed(quot[47:0]) : acc + $signed(quot[47:0]);
        OP_SCALE: begin
          back_r <= acc[47];
          mag16  <= (acc_mag >= 48'(SAT_LIMIT)) ? 16'(MAG_MAX) : prod[15:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        esum[k] <= '0;
        prev[k] <= '0;
      end
    end else if (!busy && in_xfer && req_type) begin
      for (int k = 0; k < MOTOR_COUNT; k++) begin
        esum[k] <= '0;
        prev[k] <= '0;
      end
    end else if (busy && cw.op == OP_SUM) begin
      esum[idx_q] <= 17'(sum_cl);
      prev[idx_q] <= err_r;
    end
  end

  // output register
  logic out_load;
  assign out_load = busy && cw.op == OP_OUT && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      motor_side <= side_q;
      pwm_level  <= 16'(MAG_MAX) - mag_fin;
      backward   <= back_r;
    end
  end

  // checks
  a_step_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !req_type) |=> busy)
    else $error("control step transfer did not start the sequencer");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy && cw.op == OP_OUT))
    else $error("result appeared without an output step");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && req_type) |=> (esum[0] == '0 && prev[0] == '0))
    else $error("restart left motor state nonzero");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= PROG_LAST))
    else $error("step counter ran past the program");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (busy && cw.op == OP_ACC) |-> $past(div_last))
    else $error("accumulate before the divide finished");

endmodule

`default_nettype wire

FILE: rtl/mppid_div.sv
// ----------------------------------------------------------------------------
// mppid_div: byte-serial unsigned divide by 100
// Restoring division, eight quotient bits per cycle while step is asserted. The work register
// shifts the dividend out at the top and the quotient in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module mppid_div (
  input  logic                    clk,
  input  logic                    rst,
  input  mppid_pkg::div_ctl_t     ctl,
  input  logic [mppid_pkg::DIV_W-1:0] load_val,
  output logic [mppid_pkg::DIV_W-1:0] quot,
  output logic                    last
);
  import mppid_pkg::*;

  logic [DIV_W-1:0] work;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;

  logic [7:0]       top_byte;
  logic [7:0]       qbyte;
  logic [REM_W-1:0] rem_next;
  logic [REM_W:0]   trial;

  always_comb begin
    top_byte = work[DIV_W-1 -: 8];
    rem_next = rem;
    qbyte    = '0;
    trial    = '0;
    for (int i = 7; i >= 0; i--) begin
      trial = {rem_next, top_byte[i]};
      if (trial >= (REM_W+1)'(DIVISOR)) begin
        qbyte[i] = 1'b1;
        rem_next = REM_W'(trial - (REM_W+1)'(DIVISOR));
      end else begin
        rem_next = trial[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= load_val;
      rem  <= '0;
    end else if (ctl.step) begin
      work <= {work[DIV_W-9:0], qbyte};
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign quot = work;
  assign last = (cnt == CNT_W'(DIV_BYTES - 1));

endmodule

`default_nettype wire
